>>> design/scpg_pkg.sv
`timescale 1ns / 1ps

package scpg_pkg;

    localparam int COLS_W   = 11;
    localparam int ROWS_W   = 11;
    localparam int LAYERS_W = 7;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;
    localparam int LAYER_W = 6;

    localparam int IDX_W = 26;
    localparam int POS_W = 30;

    localparam int NBR   = 14;
    localparam int NBR_W = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYERS = 2'd2;

    localparam logic [1:0] OFF_M = 2'd0;
    localparam logic [1:0] OFF_Z = 2'd1;
    localparam logic [1:0] OFF_P = 2'd2;

    typedef struct packed {
        logic       dk;
        logic [1:0] di;
        logic [1:0] dj;
    } t_off;

    typedef struct packed {
        logic [COLS_W-1:0]   cols;
        logic [ROWS_W-1:0]   rows;
        logic [LAYERS_W-1:0] layers;
        logic [IDX_W-1:0]    plane;
    } t_geom;

    typedef struct packed {
        logic             restart;
        logic             bad;
        logic [IDX_W-1:0] base;
        logic [NBR-1:0]   mask;
    } t_job;

    // Upper-triangle neighbour offsets in visiting order.
    function automatic t_off offset_of(input logic [NBR_W-1:0] k);
        t_off o;
        unique case (k)
            4'd0:    o = '{1'b0, OFF_Z, OFF_Z};
            4'd1:    o = '{1'b0, OFF_Z, OFF_P};
            4'd2:    o = '{1'b0, OFF_P, OFF_M};
            4'd3:    o = '{1'b0, OFF_P, OFF_Z};
            4'd4:    o = '{1'b0, OFF_P, OFF_P};
            4'd5:    o = '{1'b1, OFF_M, OFF_M};
            4'd6:    o = '{1'b1, OFF_M, OFF_Z};
            4'd7:    o = '{1'b1, OFF_M, OFF_P};
            4'd8:    o = '{1'b1, OFF_Z, OFF_M};
            4'd9:    o = '{1'b1, OFF_Z, OFF_Z};
            4'd10:   o = '{1'b1, OFF_Z, OFF_P};
            4'd11:   o = '{1'b1, OFF_P, OFF_M};
            4'd12:   o = '{1'b1, OFF_P, OFF_Z};
            4'd13:   o = '{1'b1, OFF_P, OFF_P};
            default: o = '{1'b0, OFF_Z, OFF_Z};
        endcase
        return o;
    endfunction

endpackage

>>> design/scpg_front.sv
`timescale 1ns / 1ps

module scpg_front
    import scpg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_restart,
    input  logic [COL_W-1:0]   i_node_col,
    input  logic [ROW_W-1:0]   i_node_row,
    input  logic [LAYER_W-1:0] i_node_layer,
    input  t_geom              i_geom,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);

    logic               r_valid;
    logic               r_restart;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [LAYER_W-1:0] r_layer;

    logic               accept;
    logic [31:0]        prod_l;
    logic [31:0]        prod_r;
    logic [COLS_W-1:0]  col_x;
    logic [ROWS_W-1:0]  row_x;
    logic [LAYERS_W-1:0] layer_x;
    logic               c_lo, c_hi, r_lo, r_hi, l_hi;
    logic               bad;
    logic [NBR-1:0]     mask;

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_restart <= i_restart;
            r_col     <= i_node_col;
            r_row     <= i_node_row;
            r_layer   <= i_node_layer;
        end
    end

    assign col_x   = COLS_W'(r_col);
    assign row_x   = ROWS_W'(r_row);
    assign layer_x = LAYERS_W'(r_layer);

    assign c_lo = (r_col != '0);
    assign r_lo = (r_row != '0);
    assign c_hi = (col_x + COLS_W'(1)) < i_geom.cols;
    assign r_hi = (row_x + ROWS_W'(1)) < i_geom.rows;
    assign l_hi = (layer_x + LAYERS_W'(1)) < i_geom.layers;

    assign bad = (col_x >= i_geom.cols) || (row_x >= i_geom.rows)
              || (layer_x >= i_geom.layers);

    always_comb begin
        t_off o;
        logic ok;
        mask = '0;
        for (int k = 0; k < NBR; k++) begin
            o  = offset_of(NBR_W'(k));
            ok = !o.dk || l_hi;
            if (o.di == OFF_M) ok = ok && r_lo;
            if (o.di == OFF_P) ok = ok && r_hi;
            if (o.dj == OFF_M) ok = ok && c_lo;
            if (o.dj == OFF_P) ok = ok && c_hi;
            mask[k] = ok;
        end
    end

    assign prod_l = 32'(r_layer) * 32'(i_geom.plane);
    assign prod_r = 32'(r_row) * 32'(i_geom.cols);

    assign o_job.restart = r_restart;
    assign o_job.bad     = bad;
    assign o_job.base    = IDX_W'(prod_l) + IDX_W'(prod_r) + IDX_W'(r_col);
    assign o_job.mask    = mask;

endmodule

>>> design/scpg_queue.sv
`timescale 1ns / 1ps

module scpg_queue
    import scpg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> design/scpg_back.sv
`timescale 1ns / 1ps

module scpg_back
    import scpg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_geom            i_geom,
    input  logic             i_q_valid,
    input  t_job             i_q_job,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_column_index,
    output logic [POS_W-1:0] o_entry_position,
    output logic [POS_W-1:0] o_row_start,
    output logic             o_last_entry,
    output logic             o_bad_node
);

    logic             r_busy;
    t_job             r_job;
    logic [NBR-1:0]   r_mask;
    logic [POS_W-1:0] r_start;
    logic [POS_W-1:0] r_count;
    logic [POS_W-1:0] n_count;

    logic             r_ovalid;
    logic [IDX_W-1:0] r_ocol;
    logic [POS_W-1:0] r_opos;
    logic [POS_W-1:0] r_ostart;
    logic             r_olast;
    logic             r_obad;

    logic             out_free;
    logic             emit;
    logic             last_now;
    logic             load;
    logic [NBR-1:0]   sel;
    logic [NBR_W-1:0] sel_idx;
    t_off             off;
    logic [IDX_W-1:0] t_dk, t_di, t_dj, cols_x, idx;

    always_comb begin
        logic found;
        found   = 1'b0;
        sel     = '0;
        sel_idx = '0;
        for (int k = 0; k < NBR; k++) begin
            if (r_mask[k] && !found) begin
                found   = 1'b1;
                sel[k]  = 1'b1;
                sel_idx = NBR_W'(k);
            end
        end
    end

    assign off    = offset_of(sel_idx);
    assign cols_x = IDX_W'(i_geom.cols);
    assign t_dk   = off.dk ? i_geom.plane : '0;

    always_comb begin
        case (off.di)
            OFF_M:   t_di = '0 - cols_x;
            OFF_P:   t_di = cols_x;
            default: t_di = '0;
        endcase
        case (off.dj)
            OFF_M:   t_dj = '1;
            OFF_P:   t_dj = IDX_W'(1);
            default: t_dj = '0;
        endcase
    end

    assign idx      = r_job.base + t_dk + t_di + t_dj;
    assign out_free = !r_ovalid || !i_stall;
    assign emit     = r_busy && out_free;
    assign last_now = r_job.bad || ((r_mask & ~sel) == '0);
    assign load     = i_q_valid && (!r_busy || (emit && last_now));
    assign o_q_pop  = load;

    always_comb begin
        n_count = r_count;
        if (emit && !r_job.bad) begin
            n_count = r_count + POS_W'(1);
        end
        if (load && i_q_job.restart) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && last_now) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job   <= i_q_job;
            r_mask  <= i_q_job.mask;
            r_start <= n_count;
        end else if (emit) begin
            r_mask <= r_mask & ~sel;
        end
        if (emit) begin
            r_ocol   <= r_job.bad ? '0 : idx;
            r_opos   <= r_count;
            r_ostart <= r_start;
            r_olast  <= last_now;
            r_obad   <= r_job.bad;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_column_index   = r_ocol;
    assign o_entry_position = r_opos;
    assign o_row_start      = r_ostart;
    assign o_last_entry     = r_olast;
    assign o_bad_node       = r_obad;

    a_mask_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_job.bad |-> r_mask != '0)
        else $error("good node in progress has no entries left");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("queue popped while empty");

    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_obad |-> r_olast && (r_ocol == '0) && (r_opos == r_ostart))
        else $error("bad node result malformed");

    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_count == r_start)
        else $error("new node does not start at the running count");

endmodule

>>> design/stencil_csr_pattern_generator.sv
`timescale 1ns / 1ps

// Builds the upper-triangle compressed-row pattern of a 27-point 3D stencil, one
// grid node per input item. A node inside the grid gives one result per kept
// neighbour, from 1 to 14, in layer, row, column order, with the last flagged; a
// node outside the grid gives a single result with bad_node set. The back-end
// sequencer emits one result per cycle unless stalled and loads the next node
// as it emits the last result of the one before, so nodes follow without gaps
// while the queue holds one. The front end classifies each node, a four-entry
// queue separates the two, and input is taken while results wait until it fills.
// Grid sizes above MAX_COLS, MAX_ROWS or MAX_LAYERS are clamped to those limits.

module stencil_csr_pattern_generator
    import scpg_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_LAYERS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_restart,
    input  logic [COL_W-1:0]     i_node_col,
    input  logic [ROW_W-1:0]     i_node_row,
    input  logic [LAYER_W-1:0]   i_node_layer,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [IDX_W-1:0]     o_column_index,
    output logic [POS_W-1:0]     o_entry_position,
    output logic [POS_W-1:0]     o_row_start,
    output logic                 o_last_entry,
    output logic                 o_bad_node
);

    localparam int COLS_LIM   = (MAX_COLS > 2047) ? 2047 : MAX_COLS;
    localparam int ROWS_LIM   = (MAX_ROWS > 2047) ? 2047 : MAX_ROWS;
    localparam int LAYERS_LIM = (MAX_LAYERS > 127) ? 127 : MAX_LAYERS;

    logic [COLS_W-1:0]   r_cols;
    logic [ROWS_W-1:0]   r_rows;
    logic [LAYERS_W-1:0] r_layers;
    logic [IDX_W-1:0]    r_plane;
    t_geom               geom;
    logic [COLS_W+ROWS_W-1:0] plane_full;

    logic q_full, q_push, q_pop, q_valid;
    t_job f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= COLS_W'(1);
            r_rows   <= ROWS_W'(1);
            r_layers <= LAYERS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COLS:   r_cols   <= i_cfg_data[COLS_W-1:0];
                REG_ROWS:   r_rows   <= i_cfg_data[ROWS_W-1:0];
                REG_LAYERS: r_layers <= i_cfg_data[LAYERS_W-1:0];
                default:    ;
            endcase
        end
    end

    assign geom.cols   = (32'(r_cols) > COLS_LIM) ? COLS_W'(COLS_LIM) : r_cols;
    assign geom.rows   = (32'(r_rows) > ROWS_LIM) ? ROWS_W'(ROWS_LIM) : r_rows;
    assign geom.layers = (32'(r_layers) > LAYERS_LIM) ? LAYERS_W'(LAYERS_LIM) : r_layers;
    assign geom.plane  = r_plane;

    assign plane_full = (COLS_W + ROWS_W)'(geom.cols) * (COLS_W + ROWS_W)'(geom.rows);

    always_ff @(posedge i_clk) begin
        r_plane <= IDX_W'(plane_full);
    end

    scpg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_restart    (i_restart),
        .i_node_col   (i_node_col),
        .i_node_row   (i_node_row),
        .i_node_layer (i_node_layer),
        .i_geom       (geom),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_job        (f_job)
    );

    scpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    scpg_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_geom           (geom),
        .i_q_valid        (q_valid),
        .i_q_job          (q_job),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_column_index   (o_column_index),
        .o_entry_position (o_entry_position),
        .o_row_start      (o_row_start),
        .o_last_entry     (o_last_entry),
        .o_bad_node       (o_bad_node)
    );

endmodule
